[design/lcms_pkg.sv]
// Shared types, widths and the control program of the lcm sum block.
package lcms_pkg;

  localparam int N_W   = 17;           // width of n
  localparam int OUT_W = 50;           // width of the result
  localparam int S_W   = 36;           // divisor-sum accumulator
  localparam int T_W   = 52;           // product register
  localparam int MUL_W = S_W + N_W;    // full multiplier product
  localparam int STEP_W = 5;

  typedef logic [STEP_W-1:0] step_t;

  // jump targets in the program
  localparam step_t L_LOOP  = 5'd0;
  localparam step_t L_WAIT1 = 5'd3;
  localparam step_t L_WAIT2 = 5'd9;
  localparam step_t L_NEXTP = 5'd14;
  localparam step_t L_FIN   = 5'd15;
  localparam step_t L_INC   = 5'd20;
  localparam step_t L_DONE  = 5'd22;

  typedef enum logic [1:0] {T_KEEP, T_MUL, T_SUB} t_op_t;
  typedef enum logic [1:0] {A_S, A_T, A_P} a_sel_t;
  typedef enum logic [1:0] {B_P, B_M, B_N} b_sel_t;
  typedef enum logic [1:0] {S_KEEP, S_ADD, S_INC} s_op_t;
  typedef enum logic [2:0] {C_NEVER, C_ALWAYS, C_SQ_GT, C_BUSY, C_REM_NZ, C_M_ONE} cond_t;

  typedef struct packed {
    t_op_t  t_op;
    a_sel_t a_sel;
    b_sel_t b_sel;
    s_op_t  s_op;
    logic   m_ld;
    logic   p_inc;
    logic   div_go;
    cond_t  cond;
    step_t  target;
    logic   last;
  } ucw_t;

  typedef struct packed {
    logic           go;
    logic [N_W-1:0] dividend;
    logic [N_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic           busy;
    logic [N_W-1:0] quo;
    logic [N_W-1:0] rem;
  } div_res_t;

  localparam ucw_t UC_NOP = '{
    t_op: T_KEEP, a_sel: A_S, b_sel: B_P, s_op: S_KEEP, m_ld: 1'b0, p_inc: 1'b0,
    div_go: 1'b0, cond: C_NEVER, target: L_LOOP, last: 1'b0
  };

  // Control program: trial division collects sum over d|n of d*phi(d) as a
  // product of per-prime factors, then the result is n*(f+1)/2.
  function automatic ucw_t ucode(input step_t step);
    ucw_t cw;
    cw = UC_NOP;
    case (step)
      5'd0: begin
        cw.t_op = T_MUL; cw.a_sel = A_P; cw.b_sel = B_P;
      end
      5'd1: begin
        cw.cond = C_SQ_GT; cw.target = L_FIN;
      end
      5'd2: cw.div_go = 1'b1;
      5'd3: begin
        cw.cond = C_BUSY; cw.target = L_WAIT1;
      end
      5'd4: begin
        cw.cond = C_REM_NZ; cw.target = L_NEXTP;
      end
      5'd5: begin
        cw.m_ld = 1'b1; cw.t_op = T_MUL; cw.a_sel = A_S; cw.b_sel = B_P;
      end
      5'd6: cw.t_op = T_SUB;
      5'd7: begin
        cw.t_op = T_MUL; cw.a_sel = A_T; cw.b_sel = B_P;
      end
      5'd8: begin
        cw.s_op = S_ADD; cw.div_go = 1'b1;
      end
      5'd9: begin
        cw.cond = C_BUSY; cw.target = L_WAIT2;
      end
      5'd10: begin
        cw.cond = C_REM_NZ; cw.target = L_NEXTP;
      end
      5'd11: begin
        cw.m_ld = 1'b1; cw.t_op = T_MUL; cw.a_sel = A_T; cw.b_sel = B_P;
      end
      5'd12: begin
        cw.t_op = T_MUL; cw.a_sel = A_T; cw.b_sel = B_P;
      end
      5'd13: begin
        cw.s_op = S_ADD; cw.div_go = 1'b1; cw.cond = C_ALWAYS; cw.target = L_WAIT2;
      end
      5'd14: begin
        cw.p_inc = 1'b1; cw.cond = C_ALWAYS; cw.target = L_LOOP;
      end
      5'd15: begin
        cw.cond = C_M_ONE; cw.target = L_INC;
      end
      5'd16: begin
        cw.t_op = T_MUL; cw.a_sel = A_S; cw.b_sel = B_M;
      end
      5'd17: cw.t_op = T_SUB;
      5'd18: begin
        cw.t_op = T_MUL; cw.a_sel = A_T; cw.b_sel = B_M;
      end
      5'd19: cw.s_op = S_ADD;
      5'd20: cw.s_op = S_INC;
      5'd21: begin
        cw.t_op = T_MUL; cw.a_sel = A_S; cw.b_sel = B_N;
      end
      5'd22: cw.last = 1'b1;
      default: cw.last = 1'b1;
    endcase
    return cw;
  endfunction

endpackage

[design/lcms_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
module lcms_div (
  input  logic                clk,
  input  logic                rst_n,
  input  lcms_pkg::div_req_t  req,
  output lcms_pkg::div_res_t  res
);

  localparam int W     = lcms_pkg::N_W;
  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem_r, quo_r, dsr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [W:0]       trial;

  assign trial = {rem_r, quo_r[W-1]} - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.go) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_r <= trial[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[W-2:0], quo_r[W-1]};
        quo_r <= {quo_r[W-2:0], 1'b0};
      end
    end
  end

  assign res.busy = busy_r;
  assign res.quo  = quo_r;
  assign res.rem  = rem_r;

endmodule

[design/lcm_sum_with_n.sv]
// Top level of the lcm sum block: handshake, microcoded sequencer and datapath.
// Returns the sum of lcm(i, n) for i = 1..n, or 0 when n is 0 or above MAX_N.
// The block factors n by trial division and forms n*(1 + sum over d|n of
// d*phi(d))/2. It tries each trial divisor p while p*p stays within the
// remaining cofactor, with further steps for each prime of n that divides
// and for each further power of it, and then forms the result. The shared
// divider runs inside the trial-division loop. A new item is taken once the
// previous one has left the sequencer, while its result may still wait in
// the output register.
module lcm_sum_with_n #(
  parameter int MAX_N = 131071
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lcms_pkg::N_W-1:0]     in_n,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lcms_pkg::OUT_W-1:0]   out_lcm_total
);

  localparam int N_W   = lcms_pkg::N_W;
  localparam int S_W   = lcms_pkg::S_W;
  localparam int T_W   = lcms_pkg::T_W;
  localparam int MUL_W = lcms_pkg::MUL_W;
  localparam int OUT_W = lcms_pkg::OUT_W;
  localparam int LIM_W = 32;
  localparam logic [LIM_W-1:0] MaxNLim = LIM_W'(MAX_N);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  lcms_pkg::step_t     step_r, step_nxt;
  logic [N_W-1:0]      n_r, n_nxt, m_r, m_nxt, p_r, p_nxt;
  logic [S_W-1:0]      s_r, s_nxt;
  logic [T_W-1:0]      t_r, t_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_total_r, out_total_nxt;

  lcms_pkg::ucw_t      cw;
  lcms_pkg::div_req_t  div_req;
  lcms_pkg::div_res_t  div_res;
  logic [S_W-1:0]      mul_a;
  logic [N_W-1:0]      mul_b;
  logic [MUL_W-1:0]    prod;
  logic                take, out_free, bad_n, jump;

  lcms_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  assign cw        = lcms_pkg::ucode(step_r);
  assign in_stall  = (state_r != ST_IDLE);
  assign take      = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign bad_n     = (in_n == '0) || ({{(LIM_W-N_W){1'b0}}, in_n} > MaxNLim);

  always_comb begin
    mul_a = s_r;
    case (cw.a_sel)
      lcms_pkg::A_S: mul_a = s_r;
      lcms_pkg::A_T: mul_a = t_r[S_W-1:0];
      lcms_pkg::A_P: mul_a = {{(S_W-N_W){1'b0}}, p_r};
      default:       mul_a = s_r;
    endcase
    mul_b = p_r;
    case (cw.b_sel)
      lcms_pkg::B_P: mul_b = p_r;
      lcms_pkg::B_M: mul_b = m_r;
      lcms_pkg::B_N: mul_b = n_r;
      default:       mul_b = p_r;
    endcase
  end

  assign prod = MUL_W'(mul_a) * MUL_W'(mul_b);

  always_comb begin
    jump = 1'b0;
    case (cw.cond)
      lcms_pkg::C_NEVER:  jump = 1'b0;
      lcms_pkg::C_ALWAYS: jump = 1'b1;
      lcms_pkg::C_SQ_GT:  jump = (t_r > {{(T_W-N_W){1'b0}}, m_r});
      lcms_pkg::C_BUSY:   jump = div_res.busy;
      lcms_pkg::C_REM_NZ: jump = (div_res.rem != '0);
      lcms_pkg::C_M_ONE:  jump = (m_r == N_W'(1));
      default:            jump = 1'b0;
    endcase
  end

  assign div_req.go       = (state_r == ST_RUN) && cw.div_go;
  assign div_req.dividend = m_r;
  assign div_req.divisor  = p_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    n_nxt         = n_r;
    m_nxt         = m_r;
    p_nxt         = p_r;
    s_nxt         = s_r;
    t_nxt         = t_r;
    out_valid_nxt = out_valid_r;
    out_total_nxt = out_total_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          n_nxt     = in_n;
          m_nxt     = in_n;
          p_nxt     = N_W'(2);
          s_nxt     = S_W'(1);
          t_nxt     = '0;
          step_nxt  = bad_n ? lcms_pkg::L_DONE : lcms_pkg::L_LOOP;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cw.last) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_total_nxt = t_r[OUT_W:1];
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end else begin
          case (cw.t_op)
            lcms_pkg::T_MUL: t_nxt = prod[T_W-1:0];
            lcms_pkg::T_SUB: t_nxt = t_r - {{(T_W-S_W){1'b0}}, s_r};
            default:         t_nxt = t_r;
          endcase
          case (cw.s_op)
            lcms_pkg::S_ADD: s_nxt = s_r + t_r[S_W-1:0];
            lcms_pkg::S_INC: s_nxt = s_r + S_W'(1);
            default:         s_nxt = s_r;
          endcase
          if (cw.m_ld) begin
            m_nxt = div_res.quo;
          end
          if (cw.p_inc) begin
            p_nxt = p_r + N_W'(1);
          end
          step_nxt = jump ? cw.target : step_r + 1'b1;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = t_r[OUT_W:1];
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    m_r         <= m_nxt;
    p_r         <= p_nxt;
    s_r         <= s_nxt;
    t_r         <= t_nxt;
    out_total_r <= out_total_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_lcm_total = out_total_r;

endmodule
